FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the leak spectrum estimator.
// Depends on nothing; include it with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define MLSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("leak estimator implication check failed");

// Plain invariant checked at every rising clock edge outside reset.
`define MLSE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("leak estimator invariant check failed");

`endif

FILE: rtl/mlse_pkg.sv
// Package of the multichannel leak spectrum estimator: widths, register codes,
// reset values and the transaction structs. Depends on nothing.
package mlse_pkg;

  // Channel count and field widths.
  localparam int CHANNELS  = 8;
  localparam int MAX_CH    = 8;
  localparam int P_W       = 32;
  localparam int CH_IDX_W  = $clog2(CHANNELS);
  localparam int PSUM_W    = P_W + CH_IDX_W;
  localparam int COEF_W    = 16;
  localparam int LEAK_W    = 13;
  localparam int FRAC_COEF = 12;
  localparam int Q8_FRAC   = 8;
  localparam int ONE_Q8    = 1 << Q8_FRAC;

  // Internal arithmetic widths.
  localparam int ACC_W     = COEF_W + PSUM_W + 1;
  localparam int Z_W       = ACC_W - FRAC_COEF - 1;
  localparam int ZSUM_W    = Z_W + CH_IDX_W;
  localparam int MUL_W     = ZSUM_W + LEAK_W;
  localparam int RES_W     = MUL_W - FRAC_COEF;

  // Sums over channels are formed in groups of this size, then combined.
  localparam int GRP       = 4;
  localparam int NGRP      = (CHANNELS + GRP - 1) / GRP;

  // Register stages from input capture to the output register.
  localparam int LATENCY   = 9;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic signed [COEF_W-1:0] ALPHA_RST = 16'sd4964;
  localparam logic signed [COEF_W-1:0] BETA_RST  = -16'sd496;
  localparam logic [LEAK_W-1:0]        LEAK_RST  = 13'd1024;

  typedef logic [P_W-1:0] power_t;

  typedef struct packed {
    power_t power_ch0;
    power_t power_ch1;
    power_t power_ch2;
    power_t power_ch3;
    power_t power_ch4;
    power_t power_ch5;
    power_t power_ch6;
    power_t power_ch7;
    logic   last_bin;
  } in_item_t;

  typedef struct packed {
    power_t leak_ch0;
    power_t leak_ch1;
    power_t leak_ch2;
    power_t leak_ch3;
    power_t leak_ch4;
    power_t leak_ch5;
    power_t leak_ch6;
    power_t leak_ch7;
    logic   frame_end;
  } out_item_t;

endpackage

FILE: rtl/mlse_zlane.sv
// One channel lane of the Z computation: weighted own and other power, then
// clipping at 1.0. Two register stages. Depends on mlse_pkg.
module mlse_zlane
  import mlse_pkg::*;
(
  input  logic                     clk,
  input  power_t                   p,
  input  logic [PSUM_W-1:0]        psum,
  input  logic signed [COEF_W-1:0] alpha,
  input  logic signed [COEF_W-1:0] beta,
  output logic [Z_W-1:0]           z
);

  localparam logic signed [ACC_W-1:0] CLIP_Q20 = ACC_W'(ONE_Q8) << FRAC_COEF;

  logic [PSUM_W-1:0]              oth;
  logic signed [COEF_W+P_W:0]     prod_a_r;
  logic signed [COEF_W+PSUM_W:0]  prod_b_r;
  logic signed [ACC_W-1:0]        acc;
  logic [Z_W-1:0]                 z_nxt;
  logic [Z_W-1:0]                 z_r;

  // Power of the other channels is never negative.
  assign oth = psum - PSUM_W'(p);

  // First stage: the two coefficient products.
  always_ff @(posedge clk) begin
    prod_a_r <= alpha * $signed({1'b0, p});
    prod_b_r <= beta * $signed({1'b0, oth});
  end

  // Second stage: add in Q.20, clip below at 1.0 and drop the coefficient fraction.
  always_comb begin
    acc = ACC_W'(prod_a_r) + ACC_W'(prod_b_r);
    if (acc < CLIP_Q20) begin
      z_nxt = Z_W'(ONE_Q8);
    end else begin
      z_nxt = acc[ACC_W-2:FRAC_COEF];
    end
  end

  always_ff @(posedge clk) begin
    z_r <= z_nxt;
  end

  assign z = z_r;

endmodule

FILE: rtl/multichannel_leak_spectrum_estimator_unit.sv
// Top level of the multichannel leak spectrum estimator: configuration
// registers, channel sums, Z lanes, leak scaling and saturation.
// Depends on mlse_pkg, mlse_zlane and assert_macros.svh.
//
//  channel   ports                                   transaction taken when
//  -------   -------------------------------------   ----------------------
//  input     start, busy, in_data                    start high, busy low
//  result    out_strobe, out_data                    out_strobe high
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid and cfg_ready
//
// Every bin passes through the nine register stages from acceptance to its result
// strobe; a new bin is taken every cycle, busy stays low.
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the coefficient registers with their default values.
// The receiver cannot stall, so the pipeline never holds; results leave in
// acceptance order, one per bin.
`include "assert_macros.svh"

module multichannel_leak_spectrum_estimator_unit
  import mlse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic signed [COEF_W-1:0] alpha_r, alpha_nxt;
  logic signed [COEF_W-1:0] beta_r, beta_nxt;
  logic [LEAK_W-1:0]        leak_r, leak_nxt;

  // Stage control and payload.
  logic [LATENCY-1:0] vld_r;
  logic [LATENCY-2:0] last_r;
  logic               accept;
  power_t             pin [MAX_CH];
  power_t             p1_r [CHANNELS];
  power_t             p2_r [CHANNELS];
  power_t             p3_r [CHANNELS];
  logic [PSUM_W-1:0]  pgrp_nxt [NGRP];
  logic [PSUM_W-1:0]  pgrp_r [NGRP];
  logic [PSUM_W-1:0]  psum_nxt;
  logic [PSUM_W-1:0]  psum_r;
  logic [Z_W-1:0]     z5 [CHANNELS];
  logic [Z_W-1:0]     z6_r [CHANNELS];
  logic [Z_W-1:0]     z7_r [CHANNELS];
  logic [ZSUM_W-1:0]  zgrp_nxt [NGRP];
  logic [ZSUM_W-1:0]  zgrp_r [NGRP];
  logic [ZSUM_W-1:0]  zsum_nxt;
  logic [ZSUM_W-1:0]  zsum_r;
  logic [MUL_W-1:0]   mul_r [CHANNELS];
  power_t             leak_arr [MAX_CH];
  out_item_t          out_nxt;
  out_item_t          out_r;

  // Handshakes: the pipeline never stalls.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Register decode for configuration writes.
  always_comb begin
    alpha_nxt = alpha_r;
    beta_nxt  = beta_r;
    leak_nxt  = leak_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA: alpha_nxt = $signed(cfg_data[COEF_W-1:0]);
        REG_BETA:  beta_nxt  = $signed(cfg_data[COEF_W-1:0]);
        REG_LEAK:  leak_nxt  = cfg_data[LEAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      beta_r  <= BETA_RST;
      leak_r  <= LEAK_RST;
    end else begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
      leak_r  <= leak_nxt;
    end
  end

  // Valid bits and the frame marker travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[LATENCY-3:0], in_data.last_bin};
  end

  // Unpack the input transaction into a channel array.
  always_comb begin
    pin[0] = in_data.power_ch0;
    pin[1] = in_data.power_ch1;
    pin[2] = in_data.power_ch2;
    pin[3] = in_data.power_ch3;
    pin[4] = in_data.power_ch4;
    pin[5] = in_data.power_ch5;
    pin[6] = in_data.power_ch6;
    pin[7] = in_data.power_ch7;
  end

  // Group sums of the powers, then the total.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      pgrp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CHANNELS) begin
          pgrp_nxt[g] = pgrp_nxt[g] + PSUM_W'(p1_r[g * GRP + k]);
        end
      end
    end
    psum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      psum_nxt = psum_nxt + pgrp_r[g];
    end
  end

  // Stages one to three: capture, group sums, total power.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      p1_r[c] <= pin[c];
      p2_r[c] <= p1_r[c];
      p3_r[c] <= p2_r[c];
    end
    pgrp_r <= pgrp_nxt;
    psum_r <= psum_nxt;
  end

  // Stages four and five: one Z lane per channel.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    mlse_zlane u_zlane (
      .clk   (clk),
      .p     (p3_r[c]),
      .psum  (psum_r),
      .alpha (alpha_r),
      .beta  (beta_r),
      .z     (z5[c])
    );
  end

  // Group sums of Z, then the total.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      zgrp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CHANNELS) begin
          zgrp_nxt[g] = zgrp_nxt[g] + ZSUM_W'(z5[g * GRP + k]);
        end
      end
    end
    zsum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      zsum_nxt = zsum_nxt + zgrp_r[g];
    end
  end

  // Stages six to eight: Z group sums, Z total, leak product.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      z6_r[c]  <= z5[c];
      z7_r[c]  <= z6_r[c];
      mul_r[c] <= (zsum_r - ZSUM_W'(z7_r[c])) * leak_r;
    end
    zgrp_r <= zgrp_nxt;
    zsum_r <= zsum_nxt;
  end

  // Stage nine: drop the coefficient fraction and saturate to 32 bits.
  always_comb begin
    for (int c = 0; c < MAX_CH; c++) begin
      leak_arr[c] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (|mul_r[c][MUL_W-1:FRAC_COEF+P_W]) begin
        leak_arr[c] = '1;
      end else begin
        leak_arr[c] = mul_r[c][FRAC_COEF+P_W-1:FRAC_COEF];
      end
    end
    out_nxt.leak_ch0  = leak_arr[0];
    out_nxt.leak_ch1  = leak_arr[1];
    out_nxt.leak_ch2  = leak_arr[2];
    out_nxt.leak_ch3  = leak_arr[3];
    out_nxt.leak_ch4  = leak_arr[4];
    out_nxt.leak_ch5  = leak_arr[5];
    out_nxt.leak_ch6  = leak_arr[6];
    out_nxt.leak_ch7  = leak_arr[7];
    out_nxt.frame_end = last_r[LATENCY-2];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = vld_r[LATENCY-1];
  assign out_data   = out_r;

  // Every accepted bin gives its strobe after the fixed latency.
  `MLSE_ASSERT_IMPL(a_latency, clk, rst_n, accept, ##LATENCY out_strobe)
  // No strobe appears without a bin accepted that has passed through every stage.
  `MLSE_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_strobe, $past(accept, LATENCY))
  // Clipped Z of lane zero never falls below 1.0.
  `MLSE_ASSERT_ALWAYS(a_z_clip, clk, rst_n, !vld_r[4] || (z5[0] >= Z_W'(ONE_Q8)))
  // The Z total covers the Z of lane zero, so its leak difference cannot wrap.
  `MLSE_ASSERT_ALWAYS(a_zsum_cover, clk, rst_n, !vld_r[6] || (zsum_r >= ZSUM_W'(z7_r[0])))

endmodule
